### hdl/lfms_pkg.sv
// shared constants, codes and controller/datapath command and status types of the
// lens focus move sequencer; no dependencies
package lfms_pkg;

  localparam int MAX_STEPS = 63;
  localparam int CODE_BITS = 10;
  localparam int STEP_BITS = $clog2(MAX_STEPS + 1);
  localparam int COUNT_IN_BITS = 8;
  localparam int SUM_BITS = ((STEP_BITS > COUNT_IN_BITS) ? STEP_BITS : COUNT_IN_BITS) + 1;
  localparam int REG_STEP_BITS = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS = CODE_BITS;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_CODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_STEPS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REGION1_END = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REGION2_END = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COARSE_INC = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MID_INC = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FINE_INC = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_LIMIT = 3'd7;

  // register reset values
  localparam int RST_INITIAL_CODE = 0;
  localparam int RST_TOTAL_STEPS = 42;
  localparam int RST_REGION1_END = 3;
  localparam int RST_REGION2_END = 5;
  localparam int RST_COARSE_INC = 40;
  localparam int RST_MID_INC = 20;
  localparam int RST_FINE_INC = 16;
  localparam int RST_CODE_LIMIT = 1023;

  localparam logic [1:0] DIR_NEAR = 2'd0;
  localparam logic [1:0] DIR_FAR = 2'd1;

  // time budget per move
  localparam int BUDGET_BITS = 16;
  localparam int FRAME_BUDGET = 1000000 / 30;
  localparam int FAST_CUT = 10000;
  localparam int PROD_BITS = CODE_BITS + BUDGET_BITS;

  localparam int PER_800 = 800;
  localparam int PER_400 = 400;
  localparam int PER_200 = 200;
  localparam int PER_100 = 100;
  localparam int PER_50 = 50;
  localparam int BUDGET_17600 = 17600;
  localparam int BUDGET_8800 = 8800;
  localparam int BUDGET_4400 = 4400;
  localparam int BUDGET_2200 = 2200;

  localparam logic [3:0] MODE_PER_800 = 4'h5;
  localparam logic [3:0] MODE_PER_400 = 4'h4;
  localparam logic [3:0] MODE_PER_200 = 4'h3;
  localparam logic [3:0] MODE_PER_100 = 4'h2;
  localparam logic [3:0] MODE_PER_50 = 4'h1;
  localparam logic [3:0] MODE_BUDGET_17600 = 4'hD;
  localparam logic [3:0] MODE_BUDGET_8800 = 4'hC;
  localparam logic [3:0] MODE_BUDGET_4400 = 4'hB;
  localparam logic [3:0] MODE_BUDGET_2200 = 4'hA;
  localparam logic [3:0] MODE_BUDGET_LOW = 4'h9;

  // write counts and settle times
  localparam int CNT_BITS = 4;
  localparam int MAX_WRITES = 10;
  localparam logic [CNT_BITS-1:0] WRITES_FAST = 4'd10;
  localparam logic [CNT_BITS-1:0] WRITES_MID = 4'd4;
  localparam logic [CNT_BITS-1:0] WRITES_SLOW = 4'd2;
  localparam logic [2:0] SETTLE_FAST = 3'd1;
  localparam logic [2:0] SETTLE_MID = 3'd4;
  localparam logic [2:0] SETTLE_SLOW = 3'd2;
  localparam int STEP_COUNT_MID = 2;
  localparam int FAST_REF_STEP = 5;

  // x / 10 as (x * RECIP10) >> RECIP10_SHIFT, exact for x below 43690
  localparam int RECIP_BITS = 16;
  localparam int RECIP10 = 52429;
  localparam int RECIP10_SHIFT = 19;
  localparam int QUO_BITS = CODE_BITS + 1 + RECIP_BITS;

  localparam int OFF_BITS = CODE_BITS + 2;

  typedef struct packed {
    logic start;
    logic step;
    logic check;
    logic plan;
    logic emit;
    logic load_err;
    logic commit;
  } lfms_cmd_t;

  typedef struct packed {
    logic illegal;
    logic same_step;
    logic sweep_done;
    logic no_move;
    logic item_last;
    logic out_free;
  } lfms_stat_t;

endpackage

### hdl/lfms_if.sv
// request and result channel interfaces of the lens focus move sequencer
// depends on lfms_pkg for the lens code width
interface lfms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] direction;
  logic [7:0] step_count;

  modport source(output valid, direction, step_count, input ready);
  modport sink(input valid, direction, step_count, output ready);
endinterface

interface lfms_out_if;
  logic                           valid;
  logic                           ready;
  logic [lfms_pkg::CODE_BITS-1:0] lens_code;
  logic [3:0]                     mode_bits;
  logic [7:0]                     bus_byte_high;
  logic [7:0]                     bus_byte_low;
  logic [2:0]                     settle_ms;
  logic                           status;
  logic                           last;

  modport source(output valid, lens_code, mode_bits, bus_byte_high, bus_byte_low,
                 settle_ms, status, last, input ready);
  modport sink(input valid, lens_code, mode_bits, bus_byte_high, bus_byte_low,
               settle_ms, status, last, output ready);
endinterface

### hdl/lens_focus_move_sequencer_top.sv
// lens focus move sequencer: one move request in, up to ten lens writes out
// the first write follows the curve sweep, check and plan after a request is taken;
// then one write per cycle while the result sink takes them
// illegal and same-step requests skip the curve sweep
// an illegal direction gives a single error result once the output is free
// synchronous reset: registers at reset values, step index 0, no result pending
module lens_focus_move_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lfms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lfms_pkg::CFG_BITS-1:0]     cfg_data,
  lfms_in_if.sink                           in_req,
  lfms_out_if.source                        out_res
);

  lfms_pkg::lfms_cmd_t  cmd;
  lfms_pkg::lfms_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;
  logic [lfms_pkg::CODE_BITS-1:0] lens_code;
  logic [3:0]           mode_bits;
  logic [7:0]           bus_byte_high;
  logic [7:0]           bus_byte_low;
  logic [2:0]           settle_ms;
  logic                 status;
  logic                 last;

  lfms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfms_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_direction      (in_req.direction),
    .in_step_count     (in_req.step_count),
    .out_ready         (out_res.ready),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_lens_code     (lens_code),
    .out_mode_bits     (mode_bits),
    .out_bus_byte_high (bus_byte_high),
    .out_bus_byte_low  (bus_byte_low),
    .out_settle_ms     (settle_ms),
    .out_status        (status),
    .out_last          (last)
  );

  assign in_req.ready = in_ready;
  assign out_res.valid = out_valid;
  assign out_res.lens_code = lens_code;
  assign out_res.mode_bits = mode_bits;
  assign out_res.bus_byte_high = bus_byte_high;
  assign out_res.bus_byte_low = bus_byte_low;
  assign out_res.settle_ms = settle_ms;
  assign out_res.status = status;
  assign out_res.last = last;

endmodule

### hdl/lfms_ctrl.sv
// controller state machine: sequences start, curve sweep, check, plan, write
// emission and the error result; depends on lfms_pkg command and status types
module lfms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfms_pkg::lfms_stat_t stat,
  output lfms_pkg::lfms_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_PLAN = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_ERR = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stat.illegal) begin
          state_next = ST_ERR;
        end else if (stat.same_step) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (stat.sweep_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        // curve does not move the right way: only the step index moves
        if (stat.no_move) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.plan = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.item_last) begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.load_err = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/lfms_dp.sv
// datapath: register bank, step index, curve sweep unit, move planning and
// the output register; depends on lfms_pkg
module lfms_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lfms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lfms_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic [1:0]                         in_direction,
  input  logic [lfms_pkg::COUNT_IN_BITS-1:0] in_step_count,
  input  logic                               out_ready,
  input  lfms_pkg::lfms_cmd_t                cmd,
  output lfms_pkg::lfms_stat_t               stat,
  output logic                               out_valid,
  output logic [lfms_pkg::CODE_BITS-1:0]     out_lens_code,
  output logic [3:0]                         out_mode_bits,
  output logic [7:0]                         out_bus_byte_high,
  output logic [7:0]                         out_bus_byte_low,
  output logic [2:0]                         out_settle_ms,
  output logic                               out_status,
  output logic                               out_last
);

  localparam int CB = lfms_pkg::CODE_BITS;
  localparam int SB = lfms_pkg::STEP_BITS;
  localparam int WB = lfms_pkg::SUM_BITS;
  localparam int RB = lfms_pkg::REG_STEP_BITS;
  localparam int PB = lfms_pkg::PROD_BITS;
  localparam int OB = lfms_pkg::OFF_BITS;
  localparam int NB = lfms_pkg::CNT_BITS;
  localparam int QB = lfms_pkg::QUO_BITS;

  // configuration registers
  logic [CB-1:0] start_code;
  logic [RB-1:0] step_span;
  logic [RB-1:0] region1_end;
  logic [RB-1:0] region2_end;
  logic [CB-1:0] coarse_increment;
  logic [CB-1:0] mid_increment;
  logic [CB-1:0] fine_increment;
  logic [CB-1:0] code_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= CB'(lfms_pkg::RST_INITIAL_CODE);
      step_span <= RB'(lfms_pkg::RST_TOTAL_STEPS);
      region1_end <= RB'(lfms_pkg::RST_REGION1_END);
      region2_end <= RB'(lfms_pkg::RST_REGION2_END);
      coarse_increment <= CB'(lfms_pkg::RST_COARSE_INC);
      mid_increment <= CB'(lfms_pkg::RST_MID_INC);
      fine_increment <= CB'(lfms_pkg::RST_FINE_INC);
      code_limit <= CB'(lfms_pkg::RST_CODE_LIMIT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        lfms_pkg::REG_INITIAL_CODE: start_code <= cfg_data[CB-1:0];
        lfms_pkg::REG_TOTAL_STEPS:  step_span <= cfg_data[RB-1:0];
        lfms_pkg::REG_REGION1_END:  region1_end <= cfg_data[RB-1:0];
        lfms_pkg::REG_REGION2_END:  region2_end <= cfg_data[RB-1:0];
        lfms_pkg::REG_COARSE_INC:   coarse_increment <= cfg_data[CB-1:0];
        lfms_pkg::REG_MID_INC:      mid_increment <= cfg_data[CB-1:0];
        lfms_pkg::REG_FINE_INC:     fine_increment <= cfg_data[CB-1:0];
        lfms_pkg::REG_CODE_LIMIT:   code_limit <= cfg_data[CB-1:0];
        default: begin
        end
      endcase
    end
  end

  // request and step state
  logic          cur_step;
  logic [SB-1:0] current_step;
  logic [SB-1:0] dest_step;
  logic [SB-1:0] sweep_end;
  logic          req_near;
  logic          req_illegal;
  logic          req_many;
  logic          same_step;

  logic [SB-1:0] top_step;
  logic [WB-1:0] near_sum;
  logic [WB-1:0] dest_w;
  logic [SB-1:0] dest_calc;
  logic [SB-1:0] far_end;

  assign cur_step = 1'b0;

  always_comb begin
    top_step = (WB'(step_span) > WB'(lfms_pkg::MAX_STEPS)) ? SB'(lfms_pkg::MAX_STEPS)
                                                           : SB'(step_span);
    near_sum = WB'(current_step) + WB'(in_step_count);
    if (in_direction == lfms_pkg::DIR_NEAR) begin
      dest_w = (near_sum > WB'(top_step)) ? WB'(top_step) : near_sum;
    end else begin
      dest_w = (WB'(in_step_count) >= WB'(current_step))
               ? '0 : WB'(current_step) - WB'(in_step_count);
    end
    // a step index left above a lowered step span clamps too
    if (dest_w > WB'(top_step)) begin
      dest_w = WB'(top_step);
    end
    dest_calc = SB'(dest_w);
    far_end = (dest_calc > current_step) ? dest_calc : current_step;
    if (far_end < SB'(lfms_pkg::FAST_REF_STEP)) begin
      far_end = SB'(lfms_pkg::FAST_REF_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_step <= '0;
    end else if (cmd.commit) begin
      current_step <= dest_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dest_step <= dest_calc;
      sweep_end <= far_end;
      req_near <= (in_direction == lfms_pkg::DIR_NEAR);
      req_illegal <= (in_direction != lfms_pkg::DIR_NEAR) &&
                     (in_direction != lfms_pkg::DIR_FAR);
      req_many <= (in_step_count > lfms_pkg::COUNT_IN_BITS'(lfms_pkg::STEP_COUNT_MID));
      same_step <= (dest_calc == current_step);
    end
  end

  // curve sweep: one step of the piecewise-linear curve per cycle
  logic [SB-1:0] sweep_idx;
  logic [CB-1:0] sweep_code;
  logic [CB-1:0] cur_code;
  logic [CB-1:0] dest_code;
  logic [CB-1:0] ref_code;
  logic [WB-1:0] idx_up;
  logic [CB-1:0] inc;
  logic [CB:0]   code_sum;
  logic [CB-1:0] code_next;
  logic          sweep_done;

  always_comb begin
    idx_up = WB'(sweep_idx) + WB'(1);
    if (idx_up <= WB'(region1_end)) begin
      inc = coarse_increment;
    end else if (idx_up <= WB'(region2_end)) begin
      inc = mid_increment;
    end else begin
      inc = fine_increment;
    end
    code_sum = (CB+1)'(sweep_code) + (CB+1)'(inc);
    code_next = (code_sum > (CB+1)'(code_limit)) ? code_limit : CB'(code_sum);
    sweep_done = (sweep_idx == sweep_end);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sweep_idx <= '0;
      sweep_code <= start_code;
    end else if (cmd.step) begin
      if (sweep_idx == current_step) begin
        cur_code <= sweep_code;
      end
      if (sweep_idx == dest_step) begin
        dest_code <= sweep_code;
      end
      if (sweep_idx == SB'(lfms_pkg::FAST_REF_STEP)) begin
        ref_code <= sweep_code;
      end
      if (!sweep_done) begin
        sweep_idx <= SB'(idx_up);
        sweep_code <= code_next;
      end
    end
  end

  // move check: distance, write count, settle time and budget
  logic [CB-1:0]              code_dist;
  logic [CB-1:0]              dist_calc;
  logic                       no_move;
  logic [NB-1:0]              writes;
  logic [2:0]                 settle;
  logic [lfms_pkg::BUDGET_BITS-1:0] budget;

  always_comb begin
    no_move = req_near ? (dest_code <= cur_code) : (dest_code >= cur_code);
    dist_calc = req_near ? (dest_code - cur_code) : (cur_code - dest_code);
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      code_dist <= dist_calc;
      if (!req_near && (dist_calc >= ref_code)) begin
        writes <= lfms_pkg::WRITES_FAST;
        settle <= lfms_pkg::SETTLE_FAST;
        budget <= lfms_pkg::BUDGET_BITS'(lfms_pkg::FRAME_BUDGET - lfms_pkg::FAST_CUT);
      end else if (req_many) begin
        writes <= lfms_pkg::WRITES_MID;
        settle <= lfms_pkg::SETTLE_MID;
        budget <= lfms_pkg::BUDGET_BITS'(lfms_pkg::FRAME_BUDGET);
      end else begin
        writes <= lfms_pkg::WRITES_SLOW;
        settle <= lfms_pkg::SETTLE_SLOW;
        budget <= lfms_pkg::BUDGET_BITS'(lfms_pkg::FRAME_BUDGET);
      end
    end
  end

  // plan: slew mode and small step
  logic [PB-1:0] bud_w;
  logic [PB-1:0] dist_w;
  logic [3:0]    mode_calc;
  logic [3:0]    mode;
  logic [CB:0]   round_up;
  logic [QB-1:0] quo_prod;
  logic [CB-1:0] small_calc;
  logic [CB-1:0] stride;

  always_comb begin
    bud_w = PB'(budget);
    dist_w = PB'(code_dist);
    // budget / dist >= k exactly when budget >= k * dist
    if (bud_w >= dist_w * PB'(lfms_pkg::PER_800)) begin
      mode_calc = lfms_pkg::MODE_PER_800;
    end else if (bud_w >= dist_w * PB'(lfms_pkg::PER_400)) begin
      mode_calc = lfms_pkg::MODE_PER_400;
    end else if (bud_w >= dist_w * PB'(lfms_pkg::PER_200)) begin
      mode_calc = lfms_pkg::MODE_PER_200;
    end else if (bud_w >= dist_w * PB'(lfms_pkg::PER_100)) begin
      mode_calc = lfms_pkg::MODE_PER_100;
    end else if (bud_w >= dist_w * PB'(lfms_pkg::PER_50)) begin
      mode_calc = lfms_pkg::MODE_PER_50;
    end else if (bud_w >= PB'(lfms_pkg::BUDGET_17600)) begin
      mode_calc = lfms_pkg::MODE_BUDGET_17600;
    end else if (bud_w >= PB'(lfms_pkg::BUDGET_8800)) begin
      mode_calc = lfms_pkg::MODE_BUDGET_8800;
    end else if (bud_w >= PB'(lfms_pkg::BUDGET_4400)) begin
      mode_calc = lfms_pkg::MODE_BUDGET_4400;
    end else if (bud_w >= PB'(lfms_pkg::BUDGET_2200)) begin
      mode_calc = lfms_pkg::MODE_BUDGET_2200;
    end else begin
      mode_calc = lfms_pkg::MODE_BUDGET_LOW;
    end

    // ceiling of the distance over the write count
    round_up = (CB+1)'(code_dist) + (CB+1)'(writes - NB'(1));
    quo_prod = QB'(round_up) * QB'(lfms_pkg::RECIP10);
    case (writes)
      lfms_pkg::WRITES_FAST: small_calc = CB'(quo_prod >> lfms_pkg::RECIP10_SHIFT);
      lfms_pkg::WRITES_MID:  small_calc = CB'(round_up >> 2);
      default:               small_calc = CB'(round_up >> 1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      mode <= mode_calc;
      stride <= small_calc;
    end
  end

  // emission: equal-stride offsets from the current code, then the destination
  logic [CB-1:0] last_off;
  logic [NB-1:0] wr_count;
  logic [OB-1:0] off_c;
  logic [OB-1:0] off_after;
  logic [OB-1:0] dist_o;
  logic          room_now;
  logic          room_after;
  logic          is_loop;
  logic          item_last;
  logic [CB-1:0] item_code;

  always_comb begin
    off_c = OB'(last_off) + OB'(stride);
    off_after = off_c + OB'(stride);
    dist_o = OB'(code_dist);
    room_now = wr_count < NB'(lfms_pkg::MAX_WRITES);
    room_after = (wr_count + NB'(1)) < NB'(lfms_pkg::MAX_WRITES);
    is_loop = (off_c <= dist_o) && room_now;
    if (is_loop) begin
      item_last = !(((off_after <= dist_o) && room_after) || ((off_c != dist_o) && room_after));
      item_code = req_near ? (cur_code + CB'(off_c)) : (cur_code - CB'(off_c));
    end else begin
      item_last = 1'b1;
      item_code = dest_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      last_off <= '0;
      wr_count <= '0;
    end else if (cmd.emit) begin
      wr_count <= wr_count + NB'(1);
      if (is_loop) begin
        last_off <= CB'(off_c);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_lens_code <= '0;
      out_mode_bits <= '0;
      out_bus_byte_high <= '0;
      out_bus_byte_low <= '0;
      out_settle_ms <= '0;
      out_status <= 1'b1;
      out_last <= 1'b1;
    end else if (cmd.emit) begin
      out_lens_code <= item_code;
      out_mode_bits <= mode;
      out_bus_byte_high <= 8'(item_code >> 4);
      out_bus_byte_low <= {item_code[3:0], mode};
      out_settle_ms <= settle;
      out_status <= 1'b0;
      out_last <= item_last;
    end
  end

  always_comb begin
    stat.illegal = req_illegal | cur_step;
    stat.same_step = same_step;
    stat.sweep_done = sweep_done;
    stat.no_move = no_move;
    stat.item_last = item_last;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

### hdl/lfms_checker.sv
// port-level checker for the lens focus move sequencer and its bind
// depends on lfms_pkg and lens_focus_move_sequencer_top
module lfms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lfms_pkg::CODE_BITS-1:0] out_lens_code,
  input logic [3:0]                     out_mode_bits,
  input logic [7:0]                     out_bus_byte_high,
  input logic [7:0]                     out_bus_byte_low,
  input logic [2:0]                     out_settle_ms,
  input logic                           out_status,
  input logic                           out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_lens_code) && $stable(out_last))
    else $error("result changed while stalled");

  // no new request while a move still has writes to deliver
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken in the middle of a move");

  // error result carries nothing but status and last
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_last && (out_lens_code == '0) &&
                                (out_mode_bits == '0) && (out_settle_ms == '0))
    else $error("malformed error result");

  // bus bytes agree with the lens code and mode
  a_bus_pack: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_status |-> (out_bus_byte_high == 8'(out_lens_code >> 4)) &&
                                 (out_bus_byte_low == {out_lens_code[3:0], out_mode_bits}))
    else $error("bus bytes do not match lens code");

  a_settle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_status |-> (out_settle_ms == 3'd1) || (out_settle_ms == 3'd2) ||
                                 (out_settle_ms == 3'd4))
    else $error("bad settle time");

endmodule

bind lens_focus_move_sequencer_top lfms_checker u_lfms_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_req.ready),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_lens_code     (out_res.lens_code),
  .out_mode_bits     (out_res.mode_bits),
  .out_bus_byte_high (out_res.bus_byte_high),
  .out_bus_byte_low  (out_res.bus_byte_low),
  .out_settle_ms     (out_res.settle_ms),
  .out_status        (out_res.status),
  .out_last          (out_res.last)
);

### sim/lens_focus_move_sequencer_top_tb.sv
// self-checking testbench of lens_focus_move_sequencer_top: predicts the lens writes of
// every accepted move request and compares them with what the block emits
// depends on lfms_pkg and the lfms_in_if / lfms_out_if channel interfaces
module lens_focus_move_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] DIR_BAD_LO = 2'd2;
  localparam logic [1:0] DIR_BAD_HI = 2'd3;

  localparam int unsigned FULL_BUDGET = 1000000 / 30;
  localparam int unsigned QUICK_BUDGET = FULL_BUDGET - 10000;
  localparam int unsigned QUICK_WRITES = 10;
  localparam logic [2:0] QUICK_SETTLE = 3'd1;
  localparam int unsigned WRITE_CAP = 10;

  localparam int IDLE_PCT = 7;
  localparam int QUIET_GAP = 100;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [lfms_pkg::CODE_BITS-1:0] lens_code;
    logic [3:0]                     mode_bits;
    logic [7:0]                     bus_byte_high;
    logic [7:0]                     bus_byte_low;
    logic [2:0]                     settle_ms;
    logic                           status;
    logic                           last;
  } lens_write_t;

  class lens_write_board;
    lens_write_t due_writes[$];
    int mismatches;
    int unsigned init_code, step_span, region1_end, region2_end;
    int unsigned coarse_inc, mid_inc, fine_inc, code_limit;
    int unsigned cur_step;

    function new();
      init_code = 0;
      step_span = 42;
      region1_end = 3;
      region2_end = 5;
      coarse_inc = 40;
      mid_inc = 20;
      fine_inc = 16;
      code_limit = 1023;
      cur_step = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [lfms_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [lfms_pkg::CFG_BITS-1:0] data);
      case (idx)
        lfms_pkg::REG_INITIAL_CODE: init_code = data;
        lfms_pkg::REG_TOTAL_STEPS: step_span = data[5:0];
        lfms_pkg::REG_REGION1_END: region1_end = data[5:0];
        lfms_pkg::REG_REGION2_END: region2_end = data[5:0];
        lfms_pkg::REG_COARSE_INC: coarse_inc = data;
        lfms_pkg::REG_MID_INC: mid_inc = data;
        lfms_pkg::REG_FINE_INC: fine_inc = data;
        lfms_pkg::REG_CODE_LIMIT: code_limit = data;
        default: ;
      endcase
    endfunction

    // piecewise-linear step curve, saturating from step one on
    function int unsigned step_code(int unsigned step);
      int unsigned v;
      v = init_code;
      for (int unsigned i = 1; i <= step; i++) begin
        if (i <= region1_end) v += coarse_inc;
        else if (i <= region2_end) v += mid_inc;
        else v += fine_inc;
        if (v > code_limit) v = code_limit;
      end
      return v;
    endfunction

    function lens_write_t pack_write(int unsigned code, logic [3:0] mode, logic [2:0] settle);
      lens_write_t w;
      logic [lfms_pkg::CODE_BITS-1:0] c;
      c = code[lfms_pkg::CODE_BITS-1:0];
      w.lens_code = c;
      w.mode_bits = mode;
      w.bus_byte_high = 8'(c >> 4);
      w.bus_byte_low = {c[3:0], mode};
      w.settle_ms = settle;
      w.status = 1'b0;
      w.last = 1'b0;
      return w;
    endfunction

    function void take_request(logic [1:0] dir, logic [7:0] cnt);
      lens_write_t w;
      int unsigned top, dest, cur_code, dest_code, code_dist, writes, budget, per;
      int unsigned stride, off, last_off, n;
      logic [3:0] mode;
      logic [2:0] settle;
      bit going_near;
      if (dir != lfms_pkg::DIR_NEAR && dir != lfms_pkg::DIR_FAR) begin
        w = '0;
        w.status = 1'b1;
        w.last = 1'b1;
        due_writes.push_back(w);
        return;
      end
      going_near = (dir == lfms_pkg::DIR_NEAR);
      top = (step_span > lfms_pkg::MAX_STEPS) ? lfms_pkg::MAX_STEPS : step_span;
      if (going_near) dest = (cur_step + cnt > top) ? top : cur_step + cnt;
      else dest = (cnt >= cur_step) ? 0 : cur_step - cnt;
      if (dest > top) dest = top;
      if (dest == cur_step) return;
      cur_code = step_code(cur_step);
      dest_code = step_code(dest);
      // flat or falling curve: step index moves, nothing is written
      if ((going_near && dest_code <= cur_code) || (!going_near && dest_code >= cur_code)) begin
        cur_step = dest;
        return;
      end
      code_dist = going_near ? dest_code - cur_code : cur_code - dest_code;
      if (!going_near && code_dist >= step_code(5)) begin
        writes = QUICK_WRITES;
        settle = QUICK_SETTLE;
        budget = QUICK_BUDGET;
      end else begin
        writes = (cnt > 2) ? 4 : 2;
        settle = 3'(writes);
        budget = FULL_BUDGET;
      end
      per = budget / code_dist;
      if (per >= 800) mode = lfms_pkg::MODE_PER_800;
      else if (per >= 400) mode = lfms_pkg::MODE_PER_400;
      else if (per >= 200) mode = lfms_pkg::MODE_PER_200;
      else if (per >= 100) mode = lfms_pkg::MODE_PER_100;
      else if (per >= 50) mode = lfms_pkg::MODE_PER_50;
      else if (budget >= 17600) mode = lfms_pkg::MODE_BUDGET_17600;
      else if (budget >= 8800) mode = lfms_pkg::MODE_BUDGET_8800;
      else if (budget >= 4400) mode = lfms_pkg::MODE_BUDGET_4400;
      else if (budget >= 2200) mode = lfms_pkg::MODE_BUDGET_2200;
      else mode = lfms_pkg::MODE_BUDGET_LOW;
      stride = (code_dist + writes - 1) / writes;
      n = 0;
      last_off = 0;
      for (off = stride; off <= code_dist && n < WRITE_CAP; off += stride) begin
        due_writes.push_back(pack_write(going_near ? cur_code + off : cur_code - off,
                                        mode, settle));
        n++;
        last_off = off;
      end
      if (last_off != code_dist && n < WRITE_CAP) begin
        due_writes.push_back(pack_write(dest_code, mode, settle));
        n++;
      end
      if (n > 0) due_writes[due_writes.size() - 1].last = 1'b1;
      cur_step = dest;
    endfunction

    function void match_write(lens_write_t got);
      lens_write_t want;
      if (due_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected write code=%0d mode=%h hi=%h lo=%h settle=%0d st=%0b last=%0b",
                   $time, got.lens_code, got.mode_bits, got.bus_byte_high, got.bus_byte_low,
                   got.settle_ms, got.status, got.last);
        return;
      end
      want = due_writes.pop_front();
      if (got.lens_code !== want.lens_code || got.mode_bits !== want.mode_bits ||
          got.bus_byte_high !== want.bus_byte_high || got.bus_byte_low !== want.bus_byte_low ||
          got.settle_ms !== want.settle_ms || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: write mismatch", $time);
          $display("  expected code=%0d mode=%h hi=%h lo=%h settle=%0d st=%0b last=%0b",
                   want.lens_code, want.mode_bits, want.bus_byte_high, want.bus_byte_low,
                   want.settle_ms, want.status, want.last);
          $display("  actual   code=%0d mode=%h hi=%h lo=%h settle=%0d st=%0b last=%0b",
                   got.lens_code, got.mode_bits, got.bus_byte_high, got.bus_byte_low,
                   got.settle_ms, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic [lfms_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [lfms_pkg::CFG_BITS-1:0]     cfg_data;

  lfms_in_if  req_ch();
  lfms_out_if res_ch();

  lens_write_board board;
  bit src_idles = 1'b1;
  bit sink_idles = 1'b1;
  int hold_left = 0;

  lens_focus_move_sequencer_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_req(req_ch),
    .out_res(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // present one move request and wait until the block takes it
  task automatic send_req(logic [1:0] dir, logic [7:0] cnt);
    while (src_idles && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.direction <= dir;
    req_ch.step_count <= cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.take_request(dir, cnt);
  endtask

  task automatic wait_results();
    req_ch.valid <= 1'b0;
    while (board.due_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [lfms_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [lfms_pkg::CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // registers change only once the block has gone quiet
  task automatic load_config(logic [9:0] init, logic [9:0] steps, logic [9:0] r1,
                             logic [9:0] r2, logic [9:0] coarse, logic [9:0] mid,
                             logic [9:0] fine, logic [9:0] limit);
    wait_results();
    repeat (QUIET_GAP) @(posedge clk);
    write_reg(lfms_pkg::REG_INITIAL_CODE, init);
    write_reg(lfms_pkg::REG_TOTAL_STEPS, steps);
    write_reg(lfms_pkg::REG_REGION1_END, r1);
    write_reg(lfms_pkg::REG_REGION2_END, r2);
    write_reg(lfms_pkg::REG_COARSE_INC, coarse);
    write_reg(lfms_pkg::REG_MID_INC, mid);
    write_reg(lfms_pkg::REG_FINE_INC, fine);
    write_reg(lfms_pkg::REG_CODE_LIMIT, limit);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(int count);
    logic [1:0] dir;
    logic [7:0] cnt;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) dir = $urandom_range(0, 1) ? DIR_BAD_HI : DIR_BAD_LO;
      else if (pick < 55) dir = lfms_pkg::DIR_NEAR;
      else dir = lfms_pkg::DIR_FAR;
      pick = $urandom_range(0, 99);
      if (pick < 5) cnt = 8'd0;
      else if (pick < 65) cnt = 8'($urandom_range(1, 8));
      else if (pick < 88) cnt = 8'($urandom_range(9, 63));
      else cnt = 8'($urandom_range(64, 255));
      send_req(dir, cnt);
    end
  endtask

  // result sink: check every accepted write, stall at random or on request
  initial begin
    lens_write_t got;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got.lens_code = res_ch.lens_code;
        got.mode_bits = res_ch.mode_bits;
        got.bus_byte_high = res_ch.bus_byte_high;
        got.bus_byte_low = res_ch.bus_byte_low;
        got.settle_ms = res_ch.settle_ms;
        got.status = res_ch.status;
        got.last = res_ch.last;
        board.match_write(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !(sink_idles && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, %0d writes still outstanding", $time, board.due_writes.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    board = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= lfms_pkg::REG_INITIAL_CODE;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.direction <= lfms_pkg::DIR_NEAR;
    req_ch.step_count <= 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset curve: 0 40 80 120 140 160 176 ... 752 at step 42
    send_req(lfms_pkg::DIR_NEAR, 8'd0);
    send_req(lfms_pkg::DIR_NEAR, 8'd1);
    send_req(lfms_pkg::DIR_NEAR, 8'd2);
    send_req(lfms_pkg::DIR_NEAR, 8'd3);
    send_req(lfms_pkg::DIR_FAR, 8'd6);
    send_req(lfms_pkg::DIR_NEAR, 8'd4);
    send_req(lfms_pkg::DIR_FAR, 8'd4);
    send_req(lfms_pkg::DIR_NEAR, 8'd7);
    send_req(lfms_pkg::DIR_NEAR, 8'd255);
    send_req(lfms_pkg::DIR_NEAR, 8'd5);
    send_req(lfms_pkg::DIR_FAR, 8'd255);
    send_req(lfms_pkg::DIR_FAR, 8'd1);
    send_req(DIR_BAD_LO, 8'd7);
    send_req(DIR_BAD_HI, 8'd255);
    send_req(lfms_pkg::DIR_NEAR, 8'd40);
    send_req(lfms_pkg::DIR_FAR, 8'd2);
    send_req(lfms_pkg::DIR_FAR, 8'd170);
    send_req(lfms_pkg::DIR_NEAR, 8'd85);

    // flat curve: zero code distance, step index still moves
    load_config(10'd100, 10'd63, 10'd3, 10'd5, 10'd0, 10'd0, 10'd0, 10'd1023);
    send_req(lfms_pkg::DIR_NEAR, 8'd10);
    send_req(lfms_pkg::DIR_FAR, 8'd3);
    send_req(lfms_pkg::DIR_NEAR, 8'd1);

    // start code above the ceiling: the curve falls
    load_config(10'd1023, 10'd20, 10'd3, 10'd5, 10'd0, 10'd0, 10'd0, 10'd0);
    send_req(lfms_pkg::DIR_NEAR, 8'd2);
    send_req(lfms_pkg::DIR_FAR, 8'd10);
    send_req(lfms_pkg::DIR_NEAR, 8'd3);

    // typical curve; sink holds off while requests keep coming
    load_config(10'($urandom_range(0, 200)), 10'($urandom_range(1, 63)),
                10'($urandom_range(0, 10)), 10'($urandom_range(0, 20)),
                10'($urandom_range(0, 80)), 10'($urandom_range(0, 40)),
                10'($urandom_range(0, 30)), 10'($urandom_range(300, 1023)));
    run_random(15);
    hold_left = HOLD_CYCLES;
    run_random(25);
    wait_results();
    run_random(15);

    // finest curve, no idling on either side
    load_config(10'd0, 10'd63, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1023);
    src_idles = 1'b0;
    sink_idles = 1'b0;
    run_random(50);
    src_idles = 1'b1;
    sink_idles = 1'b1;

    // everything saturates at the ceiling
    load_config(10'd0, 10'd63, 10'd63, 10'd63, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    run_random(45);

    load_config(10'd0, 10'd63, 10'd20, 10'd40, 10'd50, 10'd25, 10'd10, 10'd1023);
    run_random(65);

    // random register words, random upper bits on the six bit registers
    load_config(10'($urandom_range(0, 1023)),
                {4'($urandom_range(0, 15)), 6'($urandom_range(1, 63))},
                10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    run_random(60);

    // two steps only, full code swing between them
    load_config(10'd0, 10'h3C1, 10'h3FF, 10'h3C0, 10'd1023, 10'd0, 10'd0, 10'd1023);
    run_random(40);

    wait_results();
    repeat (QUIET_GAP) @(posedge clk);
    if (board.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
hdl/lfms_pkg.sv
hdl/lfms_if.sv
hdl/lfms_ctrl.sv
hdl/lfms_dp.sv
hdl/lens_focus_move_sequencer_top.sv
hdl/lfms_checker.sv
sim/lens_focus_move_sequencer_top_tb.sv
